[hdl/fsnc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package fsnc_pkg;

  localparam int unsigned BASE_LEN = 8;
  localparam int unsigned NAME_LEN = 11;
  localparam int unsigned EXT_LEN  = NAME_LEN - BASE_LEN;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] HI_LO1   = 8'd128;
  localparam logic [7:0] HI_HI1   = 8'd228;
  localparam logic [7:0] HI_LO2   = 8'd230;
  localparam logic [7:0] CASE_BIT = 8'h20;

  localparam logic [3:0] BASE_FULL = 4'(BASE_LEN);
  localparam logic [3:0] EXT_FULL  = 4'(EXT_LEN);
  localparam logic [3:0] EXT_OFS   = 4'(BASE_LEN);

  typedef enum logic [1:0] {
    PH_BASE = 2'd0,
    PH_EXT  = 2'd1,
    PH_REJ  = 2'd2
  } phase_t;

  // byte classification handed from the classifier to the core
  typedef struct packed {
    logic       is_zero;
    logic       is_dot;
    logic       is_lower;
    logic       is_legal;
    logic [7:0] upper;
  } byte_class_t;

endpackage

`default_nettype wire

[hdl/fsnc_classify.sv]
`timescale 1ns / 1ps
`default_nettype none

module fsnc_classify (
  input  wire logic [7:0]          byte_i,
  output fsnc_pkg::byte_class_t    cls_o
);
  import fsnc_pkg::*;

  logic lower;

  assign lower = (byte_i >= CH_LA) && (byte_i <= CH_LZ);

  always_comb begin
    cls_o.is_zero  = (byte_i == CH_NUL);
    cls_o.is_dot   = (byte_i == CH_DOT);
    cls_o.is_lower = lower;
    // 229 is the deleted-entry marker and stays out
    cls_o.is_legal = ((byte_i >= CH_UA) && (byte_i <= CH_UZ)) ||
                     ((byte_i >= CH_0) && (byte_i <= CH_9)) ||
                     ((byte_i >= CH_HASH) && (byte_i <= CH_RPAR)) ||
                     ((byte_i >= HI_LO1) && (byte_i <= HI_HI1)) ||
                     (byte_i >= HI_LO2) ||
                     (byte_i == CH_SPACE) || (byte_i == CH_BANG) ||
                     (byte_i == CH_DASH) || (byte_i == CH_AT) ||
                     (byte_i == CH_CARET) || (byte_i == CH_UNDER);
    cls_o.upper    = lower ? (byte_i & ~CASE_BIT) : byte_i;
  end

endmodule

`default_nettype wire

[hdl/fsnc_core.sv]
`timescale 1ns / 1ps
`default_nettype none

module fsnc_core (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en_i,
  input  wire fsnc_pkg::byte_class_t cls_i,
  output logic                       emit_o,
  output logic [63:0]                base_o,
  output logic [23:0]                ext_o,
  output logic                       ok_o
);
  import fsnc_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [3:0] pos_r, pos_nxt;
  logic [7:0] buf_r [NAME_LEN];
  logic       wr_en;
  logic [3:0] wr_addr;
  logic       clear;
  logic       active;
  logic       full;

  assign active = (phase_r == PH_BASE) || (phase_r == PH_EXT);
  assign full   = (phase_r == PH_BASE) ? (pos_r >= BASE_FULL) : (pos_r >= EXT_FULL);

  // next state
  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    if (en_i) begin
      priority if (cls_i.is_zero) begin
        phase_nxt = PH_BASE;
        pos_nxt   = '0;
      end else if (!active) begin
        phase_nxt = phase_r;
      end else if (full) begin
        phase_nxt = (phase_r == PH_BASE && cls_i.is_dot) ? PH_EXT : PH_REJ;
        pos_nxt   = '0;
      end else if (cls_i.is_lower) begin
        pos_nxt = pos_r + 4'd1;
      end else if (cls_i.is_dot && phase_r == PH_BASE) begin
        phase_nxt = PH_EXT;
        pos_nxt   = '0;
      end else if (!cls_i.is_legal) begin
        phase_nxt = PH_REJ;
        pos_nxt   = '0;
      end else begin
        pos_nxt = pos_r + 4'd1;
      end
    end
  end

  // outputs: buffer write and result
  always_comb begin
    clear   = en_i && cls_i.is_zero;
    wr_en   = en_i && !cls_i.is_zero && active && !full &&
              (cls_i.is_lower || cls_i.is_legal) &&
              !(cls_i.is_dot && phase_r == PH_BASE);
    wr_addr = (phase_r == PH_EXT) ? (pos_r + EXT_OFS) : pos_r;
    emit_o  = clear;
    ok_o    = active;
    for (int i = 0; i < int'(BASE_LEN); i++) begin
      base_o[63-8*i -: 8] = active ? buf_r[i] : 8'h00;
    end
    for (int i = 0; i < int'(EXT_LEN); i++) begin
      ext_o[23-8*i -: 8] = active ? buf_r[int'(BASE_LEN) + i] : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_BASE;
      pos_r   <= '0;
      for (int i = 0; i < int'(NAME_LEN); i++) buf_r[i] <= CH_SPACE;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      if (clear) begin
        for (int i = 0; i < int'(NAME_LEN); i++) buf_r[i] <= CH_SPACE;
      end else if (wr_en) begin
        buf_r[wr_addr] <= cls_i.upper;
      end
    end
  end

endmodule

`default_nettype wire

[hdl/fat_short_name_converter_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Ports                                   Word
// in       input      in_valid, in_stall, in_name_byte         one name byte, 0 ends the name
// out      output     out_valid, out_stall, out_base_part,     one 8.3 name per terminating 0
//                     out_ext_part, out_name_ok
//
// One byte is taken every cycle while in_stall is low; a terminating 0 byte
// reaches the output through the input register, then the result register.
// Reset (rst_n low, synchronous) empties both registers, sets the base
// phase and fills the name buffer with spaces.
// A stalled result holds its register; only a 0 byte that would need that
// register stalls the input, other bytes keep flowing.

module fat_short_name_converter_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_name_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_base_part,
  output logic [23:0]      out_ext_part,
  output logic             out_name_ok
);
  import fsnc_pkg::*;

  // input register
  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;

  // result register
  logic        out_valid_r;
  logic [63:0] base_r;
  logic [23:0] ext_r;
  logic        ok_r;

  byte_class_t cls;
  logic        out_free;
  logic        s1_go;
  logic        emit;
  logic [63:0] base_w;
  logic [23:0] ext_w;
  logic        ok_w;

  assign out_free = !out_valid_r || !out_stall;
  // only a terminating byte waits for the result register
  assign s1_go    = s1_valid_r && (!cls.is_zero || out_free);
  assign in_stall = s1_valid_r && !s1_go;

  fsnc_classify u_classify (
    .byte_i (s1_byte_r),
    .cls_o  (cls)
  );

  fsnc_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .en_i   (s1_go),
    .cls_i  (cls),
    .emit_o (emit),
    .base_o (base_w),
    .ext_o  (ext_w),
    .ok_o   (ok_w)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) s1_byte_r <= in_name_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && emit) begin
      base_r <= base_w;
      ext_r  <= ext_w;
      ok_r   <= ok_w;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_base_part = base_r;
  assign out_ext_part  = ext_r;
  assign out_name_ok   = ok_r;

endmodule

`default_nettype wire

[hdl/fsnc_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module fsnc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [7:0]  in_name_byte,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [63:0] out_base_part,
  input wire logic [23:0] out_ext_part,
  input wire logic        out_name_ok
);

  logic acc_zero;
  assign acc_zero = in_valid && !in_stall && (in_name_byte == 8'h00);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_rej_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_name_ok |-> (out_base_part == 64'd0) && (out_ext_part == 24'd0))
    else $error("rejected name carries data");

  a_ok_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_name_ok |->
      (out_base_part[63:56] != 8'h00) &&
      !((out_base_part[63:56] >= 8'h61) && (out_base_part[63:56] <= 8'h7A)))
    else $error("converted name holds a null or lower-case byte");

  a_rose_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(acc_zero, 2))
    else $error("result without a terminating byte");

  a_stall_why: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while result side is free");

endmodule

bind fat_short_name_converter_top fsnc_checker u_fsnc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_name_byte  (in_name_byte),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_base_part (out_base_part),
  .out_ext_part  (out_ext_part),
  .out_name_ok   (out_name_ok)
);

`default_nettype wire
